>>> hdl/rne_pkg.sv
// ============================================================================
// rne_pkg
// Shared types, widths and symbol tables for the Roman numeral encoder.
// ============================================================================
package rne_pkg;

    localparam int VALUE_W   = 12;
    localparam int LETTER_W  = 8;
    localparam int SYM_COUNT = 13;
    localparam int SYM_IDX_W = 4;

    localparam logic [LETTER_W-1:0] CH_NONE = 8'h00;
    localparam logic [LETTER_W-1:0] CH_I    = 8'h49;
    localparam logic [LETTER_W-1:0] CH_V    = 8'h56;
    localparam logic [LETTER_W-1:0] CH_X    = 8'h58;
    localparam logic [LETTER_W-1:0] CH_L    = 8'h4C;
    localparam logic [LETTER_W-1:0] CH_C    = 8'h43;
    localparam logic [LETTER_W-1:0] CH_D    = 8'h44;
    localparam logic [LETTER_W-1:0] CH_M    = 8'h4D;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // Capture a new value and restart at the largest symbol.
        logic skip;   // Current symbol no longer fits: move to the next one.
        logic emit;   // Write one result item into the output register.
    } rne_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_zero;   // The captured value was zero.
        logic fits;      // Remainder is at least the current symbol's weight.
        logic final_ltr; // The letter about to be emitted ends the numeral.
        logic out_free;  // The output register can take an item this cycle.
    } rne_sts_t;

    function automatic logic [VALUE_W-1:0] sym_weight(input logic [SYM_IDX_W-1:0] idx);
        logic [VALUE_W-1:0] w;
        unique case (idx)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            4'd12:   w = 12'd1;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    function automatic logic [LETTER_W-1:0] sym_first(input logic [SYM_IDX_W-1:0] idx);
        logic [LETTER_W-1:0] c;
        unique case (idx)
            4'd0:    c = CH_M;
            4'd1:    c = CH_C;
            4'd2:    c = CH_D;
            4'd3:    c = CH_C;
            4'd4:    c = CH_C;
            4'd5:    c = CH_X;
            4'd6:    c = CH_L;
            4'd7:    c = CH_X;
            4'd8:    c = CH_X;
            4'd9:    c = CH_I;
            4'd10:   c = CH_V;
            4'd11:   c = CH_I;
            4'd12:   c = CH_I;
            default: c = CH_I;
        endcase
        return c;
    endfunction

    // A result of CH_NONE means the symbol is a single letter.
    function automatic logic [LETTER_W-1:0] sym_second(input logic [SYM_IDX_W-1:0] idx);
        logic [LETTER_W-1:0] c;
        unique case (idx)
            4'd1:    c = CH_M;
            4'd3:    c = CH_D;
            4'd5:    c = CH_C;
            4'd7:    c = CH_L;
            4'd9:    c = CH_X;
            4'd11:   c = CH_V;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/roman_numeral_encoder_top.sv
// ============================================================================
// roman_numeral_encoder_top
// Converts a number into its Roman numeral, one ASCII letter per output item.
// ============================================================================
// Each input item carries a 12-bit value. The block answers with the value's
// Roman numeral, most significant symbol first, one ASCII letter per output
// item, with last set on the final letter. A value of zero gives a single
// item with letter 0, valid_res clear and last set. Values above 3999 simply
// continue the greedy rule, so 4000 comes out as four M letters. One item is
// converted at a time: a single compare-subtract unit walks the thirteen
// symbol weights from 1000 down to 1, and each step either emits a letter
// or passes over a symbol that no longer fits. An item therefore occupies
// the block for its capture, a step for each letter and a step for each
// symbol passed over, plus any time that output stall holds back; the
// longest numeral, 3888, has 15 letters. The result sits in an output
// register, so the next item is accepted as soon as the last letter has
// been written there, even while that letter still waits to be taken.
module roman_numeral_encoder_top
    import rne_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LETTER_W-1:0] letter,
    output logic                valid_res,
    output logic                last
);

    rne_cmd_t cmd;
    rne_sts_t sts;

    // The controller sequences symbol steps and letter writes.
    rne_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the remainder and the output register.
    rne_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .letter    (letter),
        .valid_res (valid_res),
        .last      (last)
    );

    // At most one datapath command is issued in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.skip, cmd.emit}))
        else $error("conflicting datapath commands");

    // A letter is only written when the output register has room for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("output register overwritten");

    // Once an item is taken, the block is busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted before the first was converted");

    // An item without a letter only ever stands for zero and ends its numeral.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> last)
        else $error("empty item not marked last");

endmodule

>>> hdl/rne_dp.sv
// ============================================================================
// rne_dp
// Datapath: remainder, symbol index, compare-subtract unit and output register.
// ============================================================================
module rne_dp
    import rne_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rne_cmd_t            cmd,
    output rne_sts_t            sts,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LETTER_W-1:0] letter,
    output logic                valid_res,
    output logic                last
);

    logic [VALUE_W-1:0]   rem_reg,    rem_next;
    logic [SYM_IDX_W-1:0] sym_reg,    sym_next;
    logic                 half_reg,   half_next;
    logic                 zero_reg,   zero_next;
    logic                 ovld_reg,   ovld_next;
    logic [LETTER_W-1:0]  letter_reg, letter_next;
    logic                 vres_reg,   vres_next;
    logic                 last_reg,   last_next;

    logic [VALUE_W-1:0]  weight;
    logic [LETTER_W-1:0] first_ch;
    logic [LETTER_W-1:0] second_ch;
    logic [VALUE_W-1:0]  diff;
    logic                two_ltr;
    logic                ends_sym;

    assign weight    = sym_weight(sym_reg);
    assign first_ch  = sym_first(sym_reg);
    assign second_ch = sym_second(sym_reg);
    assign two_ltr   = (second_ch != CH_NONE);
    assign diff      = rem_reg - weight;
    // The symbol is complete after this letter when it is single or on its second half.
    assign ends_sym  = !two_ltr || half_reg;

    assign sts.is_zero   = zero_reg;
    assign sts.fits      = (rem_reg >= weight);
    assign sts.final_ltr = zero_reg || (ends_sym && (diff == '0));
    assign sts.out_free  = !ovld_reg || !out_stall;

    always_comb
    begin
        rem_next    = rem_reg;
        sym_next    = sym_reg;
        half_next   = half_reg;
        zero_next   = zero_reg;
        letter_next = letter_reg;
        vres_next   = vres_reg;
        last_next   = last_reg;
        ovld_next   = ovld_reg && out_stall;

        if (cmd.load)
        begin
            rem_next  = value;
            sym_next  = '0;
            half_next = 1'b0;
            zero_next = (value == '0);
        end
        else if (cmd.skip)
        begin
            sym_next = sym_reg + 1'b1;
        end
        else if (cmd.emit)
        begin
            ovld_next = 1'b1;
            if (zero_reg)
            begin
                letter_next = CH_NONE;
                vres_next   = 1'b0;
                last_next   = 1'b1;
            end
            else
            begin
                vres_next = 1'b1;
                if (ends_sym)
                begin
                    letter_next = half_reg ? second_ch : first_ch;
                    rem_next    = diff;
                    half_next   = 1'b0;
                    last_next   = (diff == '0);
                end
                else
                begin
                    letter_next = first_ch;
                    half_next   = 1'b1;
                    last_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else
        begin
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        sym_reg    <= sym_next;
        half_reg   <= half_next;
        zero_reg   <= zero_next;
        letter_reg <= letter_next;
        vres_reg   <= vres_next;
        last_reg   <= last_next;
    end

    assign out_valid = ovld_reg;
    assign letter    = letter_reg;
    assign valid_res = vres_reg;
    assign last      = last_reg;

endmodule

>>> hdl/rne_ctrl.sv
// ============================================================================
// rne_ctrl
// Controller: accepts an item, then steps the datapath until the last letter.
// ============================================================================
module rne_ctrl
    import rne_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  rne_sts_t sts,
    output rne_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.is_zero || sts.fits)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit = 1'b1;
                        if (sts.final_ltr)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.skip = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sim/roman_numeral_check.sv
`timescale 1ns / 100ps
// ============================================================================
// roman_numeral_check
// Watches both channels of the Roman numeral encoder and checks every letter.
// ============================================================================
// Each accepted value is expanded into the letters its numeral should hold.
// Each accepted output item is compared field by field with the oldest
// letter still waiting. The count of failures and of letters still due are
// handed back to the testbench top.
module roman_numeral_check
    import rne_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [VALUE_W-1:0]  value,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [LETTER_W-1:0] letter,
    input  logic                valid_res,
    input  logic                last,
    output int                  failures,
    output int                  letters_due
);

    typedef struct packed {
        logic [LETTER_W-1:0] ch;
        logic                sym;
        logic                fin;
    } numeral_letter_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  weight;
        logic [LETTER_W-1:0] lead_ch;
        logic [LETTER_W-1:0] trail_ch;
    } roman_symbol_t;

    numeral_letter_t expected_letters[$];
    int              mismatches = 0;

    function automatic roman_symbol_t roman_symbol(input int idx);
        roman_symbol_t s;
        case (idx)
            0:       s = '{12'd1000, CH_M, CH_NONE};
            1:       s = '{12'd900,  CH_C, CH_M};
            2:       s = '{12'd500,  CH_D, CH_NONE};
            3:       s = '{12'd400,  CH_C, CH_D};
            4:       s = '{12'd100,  CH_C, CH_NONE};
            5:       s = '{12'd90,   CH_X, CH_C};
            6:       s = '{12'd50,   CH_L, CH_NONE};
            7:       s = '{12'd40,   CH_X, CH_L};
            8:       s = '{12'd10,   CH_X, CH_NONE};
            9:       s = '{12'd9,    CH_I, CH_X};
            10:      s = '{12'd5,    CH_V, CH_NONE};
            11:      s = '{12'd4,    CH_I, CH_V};
            default: s = '{12'd1,    CH_I, CH_NONE};
        endcase
        return s;
    endfunction

    function automatic void expect_letter(input logic [LETTER_W-1:0] ch, input logic sym);
        numeral_letter_t item;
        item.ch  = ch;
        item.sym = sym;
        item.fin = 1'b0;
        expected_letters.push_back(item);
    endfunction

    // Greedy expansion over the symbol weights, largest first. Zero gives a
    // single empty item.
    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        roman_symbol_t      s;
        int                 idx;
        rest = v;
        if (rest == '0)
            expect_letter(CH_NONE, 1'b0);
        for (idx = 0; idx < SYM_COUNT; idx++)
        begin
            s = roman_symbol(idx);
            while (rest >= s.weight && rest != '0)
            begin
                expect_letter(s.lead_ch, 1'b1);
                if (s.trail_ch != CH_NONE)
                    expect_letter(s.trail_ch, 1'b1);
                rest = rest - s.weight;
            end
        end
        expected_letters[expected_letters.size() - 1].fin = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        numeral_letter_t want;
        if (!rst_n)
        begin
            failures    <= 0;
            letters_due <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_numeral(value);
            if (out_valid && !out_stall)
            begin
                if (expected_letters.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected item letter=%h valid_res=%b last=%b",
                                 $realtime, letter, valid_res, last);
                end
                else
                begin
                    want = expected_letters.pop_front();
                    if (letter !== want.ch || valid_res !== want.sym || last !== want.fin)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch expected %h/%b/%b got %h/%b/%b",
                                     $realtime, want.ch, want.sym, want.fin,
                                     letter, valid_res, last);
                    end
                end
            end
            failures    <= mismatches;
            letters_due <= expected_letters.size();
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Top of the Roman numeral encoder testbench.
// ============================================================================
// Feeds the encoder a directed set of values (zero, every symbol weight and
// subtractive pair, the longest numeral, values past 3999, all-ones) and then
// a few hundred random values. Both sides idle in random bursts, the output
// side holds off once for a long stretch, and the tail runs without idling.
// The checker beside the block predicts and compares every letter.
module tb;
    import rne_pkg::*;

    localparam int RANDOM_ITEMS = 255;
    localparam int TAIL_ITEMS   = 40;    // final items are sent with no idling
    localparam int HOLD_AFTER   = 40;    // items sent before the long hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;    // beyond the block's longest item time
    localparam int CYCLE_LIMIT  = 400000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [VALUE_W-1:0]  value     = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [LETTER_W-1:0] letter;
    logic                valid_res;
    logic                last;

    int failures;
    int letters_due;

    logic [VALUE_W-1:0] values_to_send[$];
    int                 items_sent = 0;
    bit                 quiet_tail = 1'b0;
    int                 cycle_count = 0;

    always #1 clk = ~clk;

    roman_numeral_encoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .letter    (letter),
        .valid_res (valid_res),
        .last      (last)
    );

    roman_numeral_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .letter      (letter),
        .valid_res   (valid_res),
        .last        (last),
        .failures    (failures),
        .letters_due (letters_due)
    );

    // Safety net: even the slowest legal run ends far below this count.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side. After the sender has passed HOLD_AFTER items the receiver
    // stalls once for the long hold-off, so the output register fills and the
    // block pushes back on its input. Otherwise it stalls in short random
    // bursts until the quiet tail of the run begins.
    initial
    begin
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && items_sent >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Input side: reset, the directed values, then the random ones.
    initial
    begin
        int idx;
        int pick;

        // Zero, each symbol and subtractive pair on its own, a few runs of
        // repeated letters, the longest numeral, the top of the nominal range
        // and values past it, where a fourth M appears.
        values_to_send = '{12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd10,
                           12'd14, 12'd40, 12'd49, 12'd50, 12'd90, 12'd99, 12'd100,
                           12'd400, 12'd500, 12'd900, 12'd1000, 12'd1994, 12'd3888,
                           12'd3999, 12'd4000, 12'd4095, 12'd2730};

        // Most random values fall in the nominal range; some are zero, some
        // are small, and some lie above 3999.
        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                values_to_send.push_back('0);
            else if (pick == 1)
                values_to_send.push_back(VALUE_W'($urandom_range(4000, 4095)));
            else if (pick <= 3)
                values_to_send.push_back(VALUE_W'($urandom_range(1, 30)));
            else if (pick == 4)
                values_to_send.push_back(VALUE_W'($urandom_range(0, 4095)));
            else
                values_to_send.push_back(VALUE_W'($urandom_range(1, 3999)));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < values_to_send.size(); idx++)
        begin
            // A random gap before the item; the value is only changed once
            // the previous one has been taken.
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            in_valid <= 1'b1;
            value    <= values_to_send[idx];
            do
                @(posedge clk);
            while (in_stall);
            items_sent++;
            if (items_sent >= values_to_send.size() - TAIL_ITEMS)
                quiet_tail = 1'b1;
        end
        in_valid <= 1'b0;

        // The checker registers its count of letters still due, so the loop waits
        // for an edge before it first reads it.
        do
            @(posedge clk);
        while (letters_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hdl/rne_pkg.sv
hdl/rne_dp.sv
hdl/rne_ctrl.sv
hdl/roman_numeral_encoder_top.sv
sim/roman_numeral_check.sv
sim/tb.sv
